### sv/json_comment_stripper_core_assert.svh
// Assertion macros for the comment stripper modules, included by the queue
`ifndef JSON_COMMENT_STRIPPER_CORE_ASSERT_SVH
`define JSON_COMMENT_STRIPPER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define JCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jcs assertion failed");

// Next-cycle implication, checked out of reset
`define JCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jcs assertion failed");

`endif

### sv/jcs_pkg.sv
// Types and constants of the JSON comment stripper
package jcs_pkg;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_STAR      = 8'h2A;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_mark;
  } in_word_t;

  typedef struct packed {
    logic [7:0] kept_byte;
    logic       has_byte;
    logic       final_result;
  } out_word_t;

  typedef struct packed {
    logic      slash_first;
    logic      main_valid;
    out_word_t main;
  } plan_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_STRING = 4'b0010,
    MODE_LINE   = 4'b0100,
    MODE_BLOCK  = 4'b1000
  } scan_mode_t;

  localparam out_word_t SLASH_WORD = '{kept_byte: CH_SLASH, has_byte: 1'b1,
                                       final_result: 1'b0};

endpackage

### sv/json_comment_stripper_core.sv
// Top level of the JSON comment stripper: removes //, # and /* */ comments
// outside double-quoted strings from a byte stream. One input word is taken
// per cycle while the four-entry queue between scanner and emitter has room;
// the emitter sends one output word per cycle while out_stall is low, so a
// word that flushes a held slash with its successor yields two output words,
// which the queue absorbs. A result passes through a queue entry and then the
// output register. A word with end_mark set answers with a bare final word
// (preceded by any held slash) and returns the scanner to its start state.
module json_comment_stripper_core import jcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  plan_t     plan, head;
  logic      plan_push, pop, accept;
  q_status_t status;

  assign in_stall = status.full;
  assign accept   = in_valid && !in_stall;

  jcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .word      (in_word),
    .plan      (plan),
    .plan_push (plan_push)
  );

  jcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (plan_push),
    .push_plan (plan),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  jcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

### sv/jcs_front.sv
// Scanner: classifies each input word and plans the output words it yields
module jcs_front import jcs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_word_t word,
  output plan_t    plan,
  output logic     plan_push
);

  scan_mode_t mode_r, mode_nxt;
  logic       slash_held_r, slash_held_nxt;
  logic       star_seen_r, star_seen_nxt;
  logic [7:0] prev_r, prev_nxt;

  logic [7:0] b;
  logic       open_quote;
  logic       go;

  assign b          = word.text_byte;
  assign open_quote = (b == CH_QUOTE) && (prev_r != CH_BACKSLASH);

  always_comb begin
    mode_nxt       = mode_r;
    slash_held_nxt = slash_held_r;
    star_seen_nxt  = star_seen_r;
    prev_nxt       = prev_r;
    plan           = '0;
    go             = 1'b1;
    if (word.end_mark) begin
      plan.slash_first       = slash_held_r;
      plan.main_valid        = 1'b1;
      plan.main.final_result = 1'b1;
      mode_nxt               = MODE_NORMAL;
      slash_held_nxt         = 1'b0;
      star_seen_nxt          = 1'b0;
      prev_nxt               = '0;
    end else begin
      prev_nxt = b;
      if (slash_held_r) begin
        slash_held_nxt = 1'b0;
        if (b == CH_SLASH) begin
          mode_nxt = MODE_LINE;
          go       = 1'b0;
        end else if (b == CH_STAR) begin
          mode_nxt      = MODE_BLOCK;
          star_seen_nxt = 1'b0;
          go            = 1'b0;
        end else begin
          plan.slash_first = 1'b1;
        end
      end
      if (go) begin
        plan.main.kept_byte = b;
        plan.main.has_byte  = 1'b1;
        unique case (mode_r)
          MODE_LINE: begin
            if (b == CH_NEWLINE) begin
              mode_nxt        = MODE_NORMAL;
              plan.main_valid = 1'b1;
            end
          end
          MODE_BLOCK: begin
            if (star_seen_r && (b == CH_SLASH)) begin
              mode_nxt      = MODE_NORMAL;
              star_seen_nxt = 1'b0;
            end else begin
              star_seen_nxt = (b == CH_STAR);
            end
          end
          MODE_STRING: begin
            if (open_quote) mode_nxt = MODE_NORMAL;
            plan.main_valid = 1'b1;
          end
          default: begin
            if (open_quote) begin
              mode_nxt        = MODE_STRING;
              plan.main_valid = 1'b1;
            end else if (b == CH_HASH) begin
              mode_nxt = MODE_LINE;
            end else if (b == CH_SLASH) begin
              slash_held_nxt = 1'b1;
            end else begin
              plan.main_valid = 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign plan_push = accept && (plan.slash_first || plan.main_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_NORMAL;
      slash_held_r <= 1'b0;
      star_seen_r  <= 1'b0;
      prev_r       <= '0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      slash_held_r <= slash_held_nxt;
      star_seen_r  <= star_seen_nxt;
      prev_r       <= prev_nxt;
    end
  end

endmodule

### sv/jcs_queue.sv
// Short queue of planned output words between scanner and emitter
module jcs_queue import jcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  plan_t     push_plan,
  input  logic      pop,
  output plan_t     head,
  output q_status_t status
);

`include "json_comment_stripper_core_assert.svh"

  plan_t             entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head         = entry_r[rd_ptr_r];
  assign status.full  = (count_r == QCNT_W'(QDEPTH));
  assign status.empty = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_plan;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  `JCS_ASSERT_NOW(a_no_push_full, push, !status.full)
  `JCS_ASSERT_NOW(a_no_pop_empty, pop, !status.empty)
  `JCS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= QCNT_W'(QDEPTH))
  `JCS_ASSERT_NEXT(a_push_fills, push && !pop, !status.empty)

endmodule

### sv/jcs_back.sv
// Emitter: drains planned words into the output register
module jcs_back import jcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  plan_t     head,
  input  q_status_t status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  logic      slash_done_r, slash_done_nxt;
  logic      load;

  assign load = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    slash_done_nxt = slash_done_r;
    pop            = 1'b0;
    if (load) begin
      out_valid_nxt = !status.empty;
      if (!status.empty) begin
        if (head.slash_first && !slash_done_r) begin
          out_word_nxt = SLASH_WORD;
          if (head.main_valid) slash_done_nxt = 1'b1;
          else pop = 1'b1;
        end else begin
          out_word_nxt   = head.main;
          slash_done_nxt = 1'b0;
          pop            = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      slash_done_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      slash_done_r <= slash_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
